// File: design/btsbc_pkg.sv
package btsbc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;
  localparam int GAIN_FRAC       = 25;
  localparam int COEF_N          = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASS_B0_B1,
    REG_BASS_B2_A1,
    REG_BASS_A2,
    REG_TREBLE_B0_B1,
    REG_TREBLE_B2_A1,
    REG_TREBLE_A2,
    REG_OUT_GAIN
  } reg_idx_t;

  typedef enum logic [3:0] {
    C_LB0, C_LB1, C_LB2, C_LA1, C_LA2,
    C_HB0, C_HB1, C_HB2, C_HA1, C_HA2
  } coef_idx_t;

  typedef enum logic [3:0] {
    B_X, B_LX1, B_LX2, B_LY1, B_LY2, B_HX1, B_HX2, B_HY1, B_HY2
  } bsel_t;

  typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB} accop_t;

  typedef enum logic [1:0] {FIN_NONE, FIN_LOW, FIN_HIGH, FIN_OUT} fin_t;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;

  typedef enum logic [4:0] {
    ST_WAIT,
    ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_LFIN,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_HFIN,
    ST_GAIN, ST_OUT
  } step_t;

  typedef struct packed {
    logic      mul_en;
    logic      a_gain;
    coef_idx_t a_idx;
    bsel_t     b_sel;
    accop_t    acc_op;
    logic      acc_sh8;
    fin_t      fin;
    hold_t     hold;
    logic      jump;
    step_t     tgt;
  } ctl_t;

  // Microprogram: a product issued in one step is accumulated in the next.
  function automatic ctl_t prog_word(input step_t s);
    ctl_t w;
    w = '{mul_en: 1'b0, a_gain: 1'b0, a_idx: C_LB0, b_sel: B_X, acc_op: ACC_NOP,
          acc_sh8: 1'b0, fin: FIN_NONE, hold: HOLD_NONE, jump: 1'b0, tgt: ST_WAIT};
    case (s)
      ST_WAIT: begin
        w.hold = HOLD_IN;
      end
      ST_L0: begin
        w.mul_en = 1'b1; w.a_idx = C_LB0; w.b_sel = B_X;
      end
      ST_L1: begin
        w.mul_en = 1'b1; w.a_idx = C_LB1; w.b_sel = B_LX1;
        w.acc_op = ACC_LOAD; w.acc_sh8 = 1'b1;
      end
      ST_L2: begin
        w.mul_en = 1'b1; w.a_idx = C_LB2; w.b_sel = B_LX2;
        w.acc_op = ACC_ADD; w.acc_sh8 = 1'b1;
      end
      ST_L3: begin
        w.mul_en = 1'b1; w.a_idx = C_LA1; w.b_sel = B_LY1;
        w.acc_op = ACC_ADD; w.acc_sh8 = 1'b1;
      end
      ST_L4: begin
        w.mul_en = 1'b1; w.a_idx = C_LA2; w.b_sel = B_LY2;
        w.acc_op = ACC_SUB;
      end
      ST_L5: begin
        w.acc_op = ACC_SUB;
      end
      ST_LFIN: begin
        w.fin = FIN_LOW;
      end
      ST_H0: begin
        w.mul_en = 1'b1; w.a_idx = C_HB0; w.b_sel = B_LY1;
      end
      ST_H1: begin
        w.mul_en = 1'b1; w.a_idx = C_HB1; w.b_sel = B_HX1;
        w.acc_op = ACC_LOAD;
      end
      ST_H2: begin
        w.mul_en = 1'b1; w.a_idx = C_HB2; w.b_sel = B_HX2;
        w.acc_op = ACC_ADD;
      end
      ST_H3: begin
        w.mul_en = 1'b1; w.a_idx = C_HA1; w.b_sel = B_HY1;
        w.acc_op = ACC_ADD;
      end
      ST_H4: begin
        w.mul_en = 1'b1; w.a_idx = C_HA2; w.b_sel = B_HY2;
        w.acc_op = ACC_SUB;
      end
      ST_H5: begin
        w.acc_op = ACC_SUB;
      end
      ST_HFIN: begin
        w.fin = FIN_HIGH;
      end
      ST_GAIN: begin
        w.mul_en = 1'b1; w.a_gain = 1'b1; w.b_sel = B_HY1;
      end
      ST_OUT: begin
        w.fin = FIN_OUT; w.hold = HOLD_OUT; w.jump = 1'b1; w.tgt = ST_WAIT;
      end
      default: begin
        w.jump = 1'b1; w.tgt = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/bass_treble_shelf_biquad_cascade_top.sv
// Sequence: an item is accepted only in the wait step, then passes through
// eleven products issued one per cycle on one shared 33x32 multiplier, two
// drain steps, two rounding steps and the output step; out_tvalid rises on
// leaving the output step, which holds while an earlier result is not taken.
// Reset (synchronous, rst_n low): histories and coefficients clear, gain = unity,
// sequencer returns to its wait step, no result pending.
module bass_treble_shelf_biquad_cascade_top #(
  parameter int SAMPLE_BITS = btsbc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = btsbc_pkg::COEF_BITS_DEF,
  parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [DATA_W-1:0]                in_tdata,   // [0] sample_in
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [DATA_W-1:0]                out_tdata,  // [0] sample_out
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [btsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btsbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import btsbc_pkg::*;

  localparam int COEF_FRAC = COEF_BITS - 7;
  localparam int PW        = 65;
  localparam int ACC_W     = PW + 8 + 3;

  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX   = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] Y_MIN   = -Y_MAX - ACC_W'(1);
  localparam logic signed [PW-1:0]    G_RND   = PW'(1) <<< (GAIN_FRAC + 7);
  localparam logic signed [PW-1:0]    S_MAX   = (PW'(1) <<< (SAMPLE_BITS - 1)) - PW'(1);
  localparam logic signed [PW-1:0]    S_MIN   = -S_MAX - PW'(1);

  step_t step_r, step_nxt;
  ctl_t  ctl;
  logic  hold_now;
  logic  in_acc;

  logic signed [COEF_BITS-1:0]   coef_r [COEF_N];
  logic [31:0]                   gain_r;
  logic signed [SAMPLE_BITS-1:0] x_r, lx1_r, lx2_r;
  logic signed [31:0]            ly1_r, ly2_r, hx1_r, hx2_r, hy1_r, hy2_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          out_tvalid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic signed [32:0]            op_a;
  logic signed [31:0]            op_b;
  logic signed [ACC_W-1:0]       addend, rnd_acc;
  logic signed [31:0]            y_sat;
  logic signed [PW-1:0]          g_rnd;
  logic signed [SAMPLE_BITS-1:0] g_sat;

  assign in_tready  = (step_r == ST_WAIT);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'($unsigned(out_sample_r));

  // control word and hold condition
  always_comb begin
    ctl = prog_word(step_r);
    case (ctl.hold)
      HOLD_IN:  hold_now = !in_tvalid;
      HOLD_OUT: hold_now = out_tvalid_r && !out_tready;
      default:  hold_now = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (hold_now) begin
      step_nxt = step_r;
    end else if (ctl.jump) begin
      step_nxt = ctl.tgt;
    end else begin
      step_nxt = step_t'(step_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // operand selection
  always_comb begin
    if (ctl.a_gain) begin
      op_a = $signed({1'b0, gain_r});
    end else begin
      op_a = 33'(coef_r[ctl.a_idx]);
    end
    case (ctl.b_sel)
      B_X:     op_b = 32'(x_r);
      B_LX1:   op_b = 32'(lx1_r);
      B_LX2:   op_b = 32'(lx2_r);
      B_LY1:   op_b = ly1_r;
      B_LY2:   op_b = ly2_r;
      B_HX1:   op_b = hx1_r;
      B_HX2:   op_b = hx2_r;
      B_HY1:   op_b = hy1_r;
      B_HY2:   op_b = hy2_r;
      default: op_b = '0;
    endcase
  end

  // stage rounding and saturation, output rounding and saturation
  always_comb begin
    addend  = ctl.acc_sh8 ? (ACC_W'(prod_r) <<< 8) : ACC_W'(prod_r);
    rnd_acc = (acc_r + ACC_RND) >>> COEF_FRAC;
    if (rnd_acc > Y_MAX) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (rnd_acc < Y_MIN) begin
      y_sat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      y_sat = rnd_acc[31:0];
    end
    g_rnd = (prod_r + G_RND) >>> (GAIN_FRAC + 8);
    if (g_rnd > S_MAX) begin
      g_sat = S_MAX[SAMPLE_BITS-1:0];
    end else if (g_rnd < S_MIN) begin
      g_sat = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      g_sat = g_rnd[SAMPLE_BITS-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEF_N; i++) begin
        coef_r[i] <= '0;
      end
      gain_r <= 32'h0200_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASS_B0_B1: begin
          coef_r[C_LB0] <= cfg_data[32 +: COEF_BITS];
          coef_r[C_LB1] <= cfg_data[0 +: COEF_BITS];
        end
        REG_BASS_B2_A1: begin
          coef_r[C_LB2] <= cfg_data[32 +: COEF_BITS];
          coef_r[C_LA1] <= cfg_data[0 +: COEF_BITS];
        end
        REG_BASS_A2:    coef_r[C_LA2] <= cfg_data[0 +: COEF_BITS];
        REG_TREBLE_B0_B1: begin
          coef_r[C_HB0] <= cfg_data[32 +: COEF_BITS];
          coef_r[C_HB1] <= cfg_data[0 +: COEF_BITS];
        end
        REG_TREBLE_B2_A1: begin
          coef_r[C_HB2] <= cfg_data[32 +: COEF_BITS];
          coef_r[C_HA1] <= cfg_data[0 +: COEF_BITS];
        end
        REG_TREBLE_A2:  coef_r[C_HA2] <= cfg_data[0 +: COEF_BITS];
        REG_OUT_GAIN:   gain_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // datapath without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    case (ctl.acc_op)
      ACC_LOAD: acc_r <= addend;
      ACC_ADD:  acc_r <= acc_r + addend;
      ACC_SUB:  acc_r <= acc_r - addend;
      default:  ;
    endcase
    if (ctl.fin == FIN_OUT && !hold_now) begin
      out_sample_r <= g_sat;
    end
  end

  // filter history and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx1_r        <= '0;
      lx2_r        <= '0;
      ly1_r        <= '0;
      ly2_r        <= '0;
      hx1_r        <= '0;
      hx2_r        <= '0;
      hy1_r        <= '0;
      hy2_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      case (ctl.fin)
        FIN_LOW: begin
          lx2_r <= lx1_r;
          lx1_r <= x_r;
          ly2_r <= ly1_r;
          ly1_r <= y_sat;
        end
        FIN_HIGH: begin
          hx2_r <= hx1_r;
          hx1_r <= ly1_r;
          hy2_r <= hy1_r;
          hy1_r <= y_sat;
        end
        default: ;
      endcase
      if (ctl.fin == FIN_OUT && !hold_now) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

// File: design/btsbc_chk.sv
module btsbc_chk #(
  parameter int DATA_W = 24
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a finished item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind bass_treble_shelf_biquad_cascade_top btsbc_chk #(.DATA_W(DATA_W)) u_chk (.*);
